// ===== rtl/tpaf_pkg.sv =====
`default_nettype none

package tpaf_pkg;

  // timer width range 12 to 20
  localparam int TIMER_WIDTH_DEF = 14;

  // apb address width, registers at 4*i
  localparam int PADDR_W = 5;

  // register map
  typedef enum logic [2:0] {
    REG_MAX_DELAY     = 3'd0,
    REG_PULSE_WIDTH   = 3'd1,
    REG_SECOND_DELAY  = 3'd2,
    REG_OUTPUT_SELECT = 3'd3,
    REG_WDT_LIMIT     = 3'd4
  } reg_idx_t;

  // register reset values
  localparam logic [9:0]  MAX_DELAY_RST    = 10'd900;
  localparam logic [9:0]  PULSE_WIDTH_RST  = 10'd50;
  localparam logic [13:0] SECOND_DELAY_RST = 14'd9900;
  localparam logic        OUTPUT_SEL_RST   = 1'b0;
  localparam logic [9:0]  WDT_LIMIT_RST    = 10'd800;

  // power scale and delay step
  localparam logic [9:0] POWER_FULL = 10'd1000;
  localparam logic [9:0] STEP_MIN   = 10'd10;

  // floor(x/1000) = (x*RECIP_1000) >> RECIP_SHIFT, exact for x below 2^20
  localparam logic [20:0] RECIP_1000  = 21'd1073742;
  localparam int          RECIP_SHIFT = 30;
  localparam int          DK_W        = 31;

  // input item payload
  typedef struct packed {
    logic       zero_cross;
    logic [9:0] power_level;
    logic       run_enable;
    logic       wdt_load_valid;
    logic [9:0] wdt_load_value;
  } tick_t;

  // |10 - m| scaled by the reciprocal of 1000
  function automatic logic [DK_W-1:0] delay_coef(input logic [9:0] m);
    logic [9:0] d;
    d = (m >= STEP_MIN) ? (m - STEP_MIN) : (STEP_MIN - m);
    return DK_W'(d) * DK_W'(RECIP_1000);
  endfunction

  localparam logic [DK_W-1:0] DELAY_COEF_RST = delay_coef(MAX_DELAY_RST);

endpackage

`default_nettype wire

// ===== rtl/tpaf_if.sv =====
`default_nettype none

// tick channel
interface tpaf_tick_if;
  logic       valid;
  logic       ready;
  logic       zero_cross;
  logic [9:0] power_level;
  logic       run_enable;
  logic       wdt_load_valid;
  logic [9:0] wdt_load_value;

  modport source (output valid, zero_cross, power_level, run_enable, wdt_load_valid,
                  wdt_load_value, input ready);
  modport sink (input valid, zero_cross, power_level, run_enable, wdt_load_valid,
                wdt_load_value, output ready);
endinterface

// result channel
interface tpaf_result_if;
  logic valid;
  logic ready;
  logic gate_main;
  logic gate_second;
  logic restart_request;

  modport source (output valid, gate_main, gate_second, restart_request, input ready);
  modport sink (input valid, gate_main, gate_second, restart_request, output ready);
endinterface

`default_nettype wire

// ===== rtl/triac_phase_angle_firing_top.sv =====
// Phase-angle firing controller for a triac gate, one item per microsecond tick.
// tick channel (valid/ready): zero-cross flag, power level 0..1000 (above
// saturates), run enable and a watchdog load. result channel (valid/ready):
// gate_main, gate_second and restart_request, exactly one result per tick item.
// APB port: five registers at byte addresses 0,4,8,12,16; pready is always high.
// An accepted item is held in an input register; the single-pass update
// of the timer, gate and watchdog state then writes the result register
// once the result register is empty or being drained.
// Throughput, while the receiver does not stall, is one item per cycle; the
// path is bounded by one 10x31 multiply for the firing delay (coefficient
// precomputed on the max_delay_steps write). A stalled result register holds
// its item; the input register keeps taking items only while the result
// register can drain, so ready drops after one buffered item on a stall.
// Reset (rst, synchronous) clears the firing state, watchdog count and both
// channels and returns the registers to their reset values.
`default_nettype none

module triac_phase_angle_firing_top
  import tpaf_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  tpaf_tick_if.sink               tick,
  tpaf_result_if.source           result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int WW = (TIMER_WIDTH > 15) ? TIMER_WIDTH : 15;
  localparam logic [WW-1:0] TMASK = WW'((64'd1 << TIMER_WIDTH) - 64'd1);

  // saturate a tick count to the timer width
  function automatic logic [TIMER_WIDTH-1:0] sat_ticks(input logic [WW-1:0] t);
    return (t > TMASK) ? TMASK[TIMER_WIDTH-1:0] : t[TIMER_WIDTH-1:0];
  endfunction

  // configuration registers
  logic [9:0]      max_delay_steps;
  logic [9:0]      pulse_width_ticks;
  logic [13:0]     second_delay_ticks;
  logic            output_select;
  logic [9:0]      watchdog_limit;
  logic [DK_W-1:0] delay_k;

  // pipeline registers
  logic  s1_valid;
  tick_t s1;
  logic  advance;

  // firing state
  logic                   fire_pending, fire_pending_next;
  logic                   second_done, second_done_next;
  logic                   timer_running, timer_running_next;
  logic [TIMER_WIDTH-1:0] timer_count, timer_count_next;
  logic [TIMER_WIDTH-1:0] alarm_value, alarm_value_next;
  logic                   gate_level, gate_level_next;
  logic [9:0]             watchdog_count, watchdog_count_next;
  logic                   running, running_next;
  logic                   restart;

  // firing delay datapath
  logic [9:0]        power_sat;
  logic [DK_W+9:0]   delay_prod;
  logic [10:0]       delay_quot;
  logic [10:0]       delay_steps;
  logic [14:0]       delay_ticks;
  logic [10:0]       wdt_inc;

  logic cfg_write;

  // apb access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[4:2])
      REG_MAX_DELAY:     prdata = 32'(max_delay_steps);
      REG_PULSE_WIDTH:   prdata = 32'(pulse_width_ticks);
      REG_SECOND_DELAY:  prdata = 32'(second_delay_ticks);
      REG_OUTPUT_SELECT: prdata = 32'(output_select);
      REG_WDT_LIMIT:     prdata = 32'(watchdog_limit);
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_delay_steps    <= MAX_DELAY_RST;
      delay_k            <= DELAY_COEF_RST;
      pulse_width_ticks  <= PULSE_WIDTH_RST;
      second_delay_ticks <= SECOND_DELAY_RST;
      output_select      <= OUTPUT_SEL_RST;
      watchdog_limit     <= WDT_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_MAX_DELAY: begin
          max_delay_steps <= pwdata[9:0];
          delay_k         <= delay_coef(pwdata[9:0]);
        end
        REG_PULSE_WIDTH:   pulse_width_ticks  <= pwdata[9:0];
        REG_SECOND_DELAY:  second_delay_ticks <= pwdata[13:0];
        REG_OUTPUT_SELECT: output_select      <= pwdata[0];
        REG_WDT_LIMIT:     watchdog_limit     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // handshake: input register drains into the result register
  assign advance    = s1_valid && (!result.valid || result.ready);
  assign tick.ready = !s1_valid || advance;

  // firing delay: 10 * (m - sign * floor(power*|10-m|/1000))
  always_comb begin
    power_sat   = (s1.power_level > POWER_FULL) ? POWER_FULL : s1.power_level;
    delay_prod  = (DK_W+10)'(power_sat) * (DK_W+10)'(delay_k);
    delay_quot  = delay_prod[RECIP_SHIFT +: 11];
    delay_steps = (max_delay_steps >= STEP_MIN) ? ({1'b0, max_delay_steps} - delay_quot)
                                                : ({1'b0, max_delay_steps} + delay_quot);
    delay_ticks = {1'b0, delay_steps, 3'b000} + {3'b000, delay_steps, 1'b0};
  end

  // one tick of the controller
  always_comb begin
    fire_pending_next   = fire_pending;
    second_done_next    = second_done;
    timer_running_next  = timer_running;
    timer_count_next    = timer_count;
    alarm_value_next    = alarm_value;
    gate_level_next     = gate_level;
    watchdog_count_next = s1.wdt_load_valid ? s1.wdt_load_value : watchdog_count;
    running_next        = running;
    restart             = 1'b0;
    wdt_inc             = 11'd0;

    if (!s1.run_enable) begin
      fire_pending_next  = 1'b0;
      timer_running_next = 1'b0;
      timer_count_next   = '0;
      gate_level_next    = 1'b0;
      running_next       = 1'b0;
    end else begin
      running_next = 1'b1;
      // timer advance and alarm
      if (timer_running) begin
        timer_count_next = timer_count + 1'b1;
        if (timer_count_next >= alarm_value) begin
          timer_count_next = '0;
          if (watchdog_count_next != 10'd0) begin
            wdt_inc = {1'b0, watchdog_count_next} + 11'd1;
            if (wdt_inc > {1'b0, watchdog_limit}) begin
              restart = 1'b1;
            end else begin
              watchdog_count_next = wdt_inc[9:0];
            end
          end
          if (!restart) begin
            if (fire_pending) begin
              gate_level_next    = 1'b1;
              alarm_value_next   = sat_ticks(WW'(pulse_width_ticks));
              timer_count_next   = '0;
              timer_running_next = 1'b1;
              fire_pending_next  = 1'b0;
            end else begin
              gate_level_next = 1'b0;
              if (!second_done) begin
                fire_pending_next  = 1'b1;
                second_done_next   = 1'b1;
                alarm_value_next   = sat_ticks(WW'(second_delay_ticks));
                timer_count_next   = '0;
                timer_running_next = 1'b1;
              end else begin
                timer_running_next = 1'b0;
              end
            end
          end
        end
      end
      // zero cross starts the firing delay
      if (!restart && s1.zero_cross && !fire_pending_next) begin
        gate_level_next = 1'b0;
        if (power_sat != 10'd0) begin
          fire_pending_next  = 1'b1;
          second_done_next   = 1'b0;
          alarm_value_next   = sat_ticks(WW'(delay_ticks));
          timer_count_next   = '0;
          timer_running_next = 1'b1;
        end else begin
          timer_running_next = 1'b0;
        end
      end
    end

    // watchdog trip returns the state to reset
    if (restart) begin
      fire_pending_next   = 1'b0;
      second_done_next    = 1'b0;
      timer_running_next  = 1'b0;
      timer_count_next    = '0;
      alarm_value_next    = '0;
      gate_level_next     = 1'b0;
      watchdog_count_next = 10'd0;
      running_next        = 1'b0;
    end
  end

  // state, input register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      result.valid   <= 1'b0;
      fire_pending   <= 1'b0;
      second_done    <= 1'b0;
      timer_running  <= 1'b0;
      timer_count    <= '0;
      alarm_value    <= '0;
      gate_level     <= 1'b0;
      watchdog_count <= 10'd0;
      running        <= 1'b0;
    end else begin
      if (tick.valid && tick.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        result.valid   <= 1'b1;
        fire_pending   <= fire_pending_next;
        second_done    <= second_done_next;
        timer_running  <= timer_running_next;
        timer_count    <= timer_count_next;
        alarm_value    <= alarm_value_next;
        gate_level     <= gate_level_next;
        watchdog_count <= watchdog_count_next;
        running        <= running_next;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1.zero_cross     <= tick.zero_cross;
      s1.power_level    <= tick.power_level;
      s1.run_enable     <= tick.run_enable;
      s1.wdt_load_valid <= tick.wdt_load_valid;
      s1.wdt_load_value <= tick.wdt_load_value;
    end
    if (advance) begin
      result.gate_main       <= !restart && gate_level_next && !output_select;
      result.gate_second     <= !restart && gate_level_next && output_select;
      result.restart_request <= restart;
    end
  end

`ifndef SYNTHESIS
  // a restart result never drives a gate
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.restart_request |-> !result.gate_main && !result.gate_second)
    else $error("gate driven on restart result");

  // the gate goes to one output only
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.gate_main && result.gate_second))
    else $error("both gate outputs high");

  // dropping enable stops the timer
  assert property (@(posedge clk) disable iff (rst)
    advance && !s1.run_enable |=> !running && !timer_running && !gate_level)
    else $error("state not cleared after enable low");

  // a running timer never passes its alarm value
  assert property (@(posedge clk) disable iff (rst)
    timer_running |-> timer_count <= alarm_value)
    else $error("timer count beyond alarm value");
`endif

endmodule

`default_nettype wire
